>>> sv/pmcs_pkg.sv
// Shared types, constants and the edge crossing test for the polygon mask
// color subtract block. No dependencies.
`default_nettype none

package pmcs_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int COORD_BITS   = 12;

  localparam int VIDX_W   = $clog2(MAX_VERTICES);
  localparam int VINDEX_W = 5;
  localparam int PCNT_W   = 6;
  localparam int POWER_W  = 7;
  localparam int CHAN_W   = 8;
  localparam int SPAN_W   = 13;
  localparam int PROD_W   = CHAN_W + POWER_W;
  localparam int AMT_W    = 9;

  localparam int PCT_RECIP   = 5243;
  localparam int PCT_SHIFT   = 19;
  localparam int RECIP_W     = 13;
  localparam int SCALED_W    = PROD_W + RECIP_W;

  localparam int BORDER = 5;

  localparam int CNT_CMP_W = (VIDX_W > PCNT_W) ? VIDX_W : PCNT_W;
  localparam int IDX_CMP_W = (VIDX_W > VINDEX_W) ? VIDX_W : VINDEX_W;
  localparam int WIN_W     = (COORD_BITS + 1 > SPAN_W) ? COORD_BITS + 1 : SPAN_W;

  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int DATA_W    = 32;

  typedef enum logic {
    CMD_VERTEX = 1'b0,
    CMD_PIXEL  = 1'b1
  } cmd_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_POINT_COUNT = 3'd0,
    REG_POWER       = 3'd1,
    REG_SUB_RED     = 3'd2,
    REG_SUB_GREEN   = 3'd3,
    REG_SUB_BLUE    = 3'd4,
    REG_IMAGE_WIDTH = 3'd5,
    REG_ROW_FIRST   = 3'd6,
    REG_ROW_LAST    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [PCNT_W-1:0] point_count;
    logic [AMT_W-1:0]  amt_red;
    logic [AMT_W-1:0]  amt_green;
    logic [AMT_W-1:0]  amt_blue;
    logic [SPAN_W-1:0] image_width;
    logic [SPAN_W-1:0] row_first;
    logic [SPAN_W-1:0] row_last;
  } cfg_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [VINDEX_W-1:0]   vidx;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [CHAN_W-1:0]     r;
    logic [CHAN_W-1:0]     g;
    logic [CHAN_W-1:0]     b;
    logic                  has_prev;
    logic [COORD_BITS-1:0] prev_x;
    logic [COORD_BITS-1:0] prev_y;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic                  parity;
  } item_t;

  // Ray crossing of the edge from (xj,yj) to (xi,yi) right of point (px,py).
  function automatic logic crosses(
    input logic [COORD_BITS-1:0] px,
    input logic [COORD_BITS-1:0] py,
    input logic [COORD_BITS-1:0] xi,
    input logic [COORD_BITS-1:0] yi,
    input logic [COORD_BITS-1:0] xj,
    input logic [COORD_BITS-1:0] yj
  );
    logic signed [COORD_BITS:0]     d;
    logic signed [COORD_BITS:0]     dx;
    logic signed [COORD_BITS:0]     ex;
    logic signed [COORD_BITS:0]     ey;
    logic signed [2*COORD_BITS+1:0] lhs;
    logic signed [2*COORD_BITS+1:0] rhs;
    logic                           straddle;
    logic                           hit;
    d        = signed'({1'b0, yj}) - signed'({1'b0, yi});
    dx       = signed'({1'b0, px}) - signed'({1'b0, xi});
    ex       = signed'({1'b0, xj}) - signed'({1'b0, xi});
    ey       = signed'({1'b0, py}) - signed'({1'b0, yi});
    lhs      = dx * d;
    rhs      = ex * ey;
    straddle = (yi > py) != (yj > py);
    hit      = (d > 0) ? (lhs < rhs) : (lhs > rhs);
    return straddle && hit;
  endfunction

endpackage

`default_nettype wire

>>> sv/pmcs_cfg.sv
// APB register file for the polygon mask block, with the scaled subtract
// amounts derived from the power setting. Depends on pmcs_pkg.
`default_nettype none

module pmcs_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pmcs_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [pmcs_pkg::DATA_W-1:0]  pwdata,
  output logic      [pmcs_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output pmcs_pkg::cfg_t                    cfg
);

  logic [pmcs_pkg::PCNT_W-1:0]   point_count;
  logic [pmcs_pkg::POWER_W-1:0]  power_percent;
  logic [pmcs_pkg::CHAN_W-1:0]   sub_red;
  logic [pmcs_pkg::CHAN_W-1:0]   sub_green;
  logic [pmcs_pkg::CHAN_W-1:0]   sub_blue;
  logic [pmcs_pkg::SPAN_W-1:0]   image_width;
  logic [pmcs_pkg::SPAN_W-1:0]   row_first;
  logic [pmcs_pkg::SPAN_W-1:0]   row_last;

  logic [pmcs_pkg::PROD_W-1:0]   prod_red;
  logic [pmcs_pkg::PROD_W-1:0]   prod_green;
  logic [pmcs_pkg::PROD_W-1:0]   prod_blue;
  logic [pmcs_pkg::SCALED_W-1:0] scaled_red;
  logic [pmcs_pkg::SCALED_W-1:0] scaled_green;
  logic [pmcs_pkg::SCALED_W-1:0] scaled_blue;
  logic [pmcs_pkg::AMT_W-1:0]    amt_red;
  logic [pmcs_pkg::AMT_W-1:0]    amt_green;
  logic [pmcs_pkg::AMT_W-1:0]    amt_blue;

  logic                          wr_en;
  pmcs_pkg::reg_idx_t            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = pmcs_pkg::reg_idx_t'(paddr[pmcs_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= '0;
      power_percent <= '0;
      sub_red       <= '0;
      sub_green     <= '0;
      sub_blue      <= '0;
      image_width   <= '0;
      row_first     <= '0;
      row_last      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        pmcs_pkg::REG_POINT_COUNT: point_count   <= pwdata[pmcs_pkg::PCNT_W-1:0];
        pmcs_pkg::REG_POWER:       power_percent <= pwdata[pmcs_pkg::POWER_W-1:0];
        pmcs_pkg::REG_SUB_RED:     sub_red       <= pwdata[pmcs_pkg::CHAN_W-1:0];
        pmcs_pkg::REG_SUB_GREEN:   sub_green     <= pwdata[pmcs_pkg::CHAN_W-1:0];
        pmcs_pkg::REG_SUB_BLUE:    sub_blue      <= pwdata[pmcs_pkg::CHAN_W-1:0];
        pmcs_pkg::REG_IMAGE_WIDTH: image_width   <= pwdata[pmcs_pkg::SPAN_W-1:0];
        pmcs_pkg::REG_ROW_FIRST:   row_first     <= pwdata[pmcs_pkg::SPAN_W-1:0];
        pmcs_pkg::REG_ROW_LAST:    row_last      <= pwdata[pmcs_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pmcs_pkg::REG_POINT_COUNT: prdata = pmcs_pkg::DATA_W'(point_count);
      pmcs_pkg::REG_POWER:       prdata = pmcs_pkg::DATA_W'(power_percent);
      pmcs_pkg::REG_SUB_RED:     prdata = pmcs_pkg::DATA_W'(sub_red);
      pmcs_pkg::REG_SUB_GREEN:   prdata = pmcs_pkg::DATA_W'(sub_green);
      pmcs_pkg::REG_SUB_BLUE:    prdata = pmcs_pkg::DATA_W'(sub_blue);
      pmcs_pkg::REG_IMAGE_WIDTH: prdata = pmcs_pkg::DATA_W'(image_width);
      pmcs_pkg::REG_ROW_FIRST:   prdata = pmcs_pkg::DATA_W'(row_first);
      pmcs_pkg::REG_ROW_LAST:    prdata = pmcs_pkg::DATA_W'(row_last);
      default:                   prdata = '0;
    endcase
  end

  // amount * power, then divide by 100 through the reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_red     <= '0;
      prod_green   <= '0;
      prod_blue    <= '0;
      scaled_red   <= '0;
      scaled_green <= '0;
      scaled_blue  <= '0;
    end else begin
      prod_red     <= pmcs_pkg::PROD_W'(sub_red) * pmcs_pkg::PROD_W'(power_percent);
      prod_green   <= pmcs_pkg::PROD_W'(sub_green) * pmcs_pkg::PROD_W'(power_percent);
      prod_blue    <= pmcs_pkg::PROD_W'(sub_blue) * pmcs_pkg::PROD_W'(power_percent);
      scaled_red   <= pmcs_pkg::SCALED_W'(prod_red) *
                      pmcs_pkg::SCALED_W'(pmcs_pkg::PCT_RECIP);
      scaled_green <= pmcs_pkg::SCALED_W'(prod_green) *
                      pmcs_pkg::SCALED_W'(pmcs_pkg::PCT_RECIP);
      scaled_blue  <= pmcs_pkg::SCALED_W'(prod_blue) *
                      pmcs_pkg::SCALED_W'(pmcs_pkg::PCT_RECIP);
    end
  end

  assign amt_red   = scaled_red[pmcs_pkg::PCT_SHIFT +: pmcs_pkg::AMT_W];
  assign amt_green = scaled_green[pmcs_pkg::PCT_SHIFT +: pmcs_pkg::AMT_W];
  assign amt_blue  = scaled_blue[pmcs_pkg::PCT_SHIFT +: pmcs_pkg::AMT_W];

  always_comb begin
    cfg.point_count = point_count;
    cfg.amt_red     = amt_red;
    cfg.amt_green   = amt_green;
    cfg.amt_blue    = amt_blue;
    cfg.image_width = image_width;
    cfg.row_first   = row_first;
    cfg.row_last    = row_last;
  end

endmodule

`default_nettype wire

>>> sv/pmcs_cell.sv
// One vertex cell of the polygon chain: holds one vertex, tests the edge to
// the vertex before it and hands the item on. Depends on pmcs_pkg.
`default_nettype none

module pmcs_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,
  input  wire logic [pmcs_pkg::VIDX_W-1:0] cell_index,
  input  wire logic [pmcs_pkg::PCNT_W-1:0] point_count,
  input  wire logic                        in_valid,
  input  wire pmcs_pkg::item_t             in_item,
  output logic                             out_valid,
  output pmcs_pkg::item_t                  out_item
);

  logic [pmcs_pkg::COORD_BITS-1:0] own_x;
  logic [pmcs_pkg::COORD_BITS-1:0] own_y;
  logic                            active;
  logic                            hit_write;
  logic                            edge_hit;
  pmcs_pkg::item_t                 item_next;

  assign active = pmcs_pkg::CNT_CMP_W'(cell_index) < pmcs_pkg::CNT_CMP_W'(point_count);
  assign hit_write = in_valid && (in_item.cmd == pmcs_pkg::CMD_VERTEX) &&
                     (pmcs_pkg::IDX_CMP_W'(in_item.vidx) ==
                      pmcs_pkg::IDX_CMP_W'(cell_index));
  assign edge_hit = pmcs_pkg::crosses(in_item.px, in_item.py, own_x, own_y,
                                      in_item.prev_x, in_item.prev_y);

  always_comb begin
    item_next = in_item;
    if (in_item.cmd == pmcs_pkg::CMD_PIXEL && active) begin
      if (in_item.has_prev) begin
        item_next.parity = in_item.parity ^ edge_hit;
      end else begin
        item_next.first_x = own_x;
        item_next.first_y = own_y;
      end
      item_next.prev_x   = own_x;
      item_next.prev_y   = own_y;
      item_next.has_prev = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item_next;
    end
    if (advance && hit_write) begin
      own_x <= in_item.px;
      own_y <= in_item.py;
    end
  end

`ifndef SYNTHESIS
  a_active_marks_prev: assert property (@(posedge clk) disable iff (rst)
    advance && in_valid && in_item.cmd == pmcs_pkg::CMD_PIXEL && active |=>
      out_item.has_prev && out_item.prev_x == $past(own_x) &&
      out_item.prev_y == $past(own_y))
    else $error("active cell did not hand on its vertex");
`endif

endmodule

`default_nettype wire

>>> sv/pmcs_finish.sv
// Last stage of the polygon chain: closing edge, window test, color subtract
// and the output register with its handshake. Depends on pmcs_pkg.
`default_nettype none

module pmcs_finish (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pmcs_pkg::cfg_t              cfg,
  input  wire logic                        in_valid,
  input  wire pmcs_pkg::item_t             in_item,
  output logic                             advance,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [pmcs_pkg::CHAN_W-1:0] out_red,
  output logic      [pmcs_pkg::CHAN_W-1:0] out_green,
  output logic      [pmcs_pkg::CHAN_W-1:0] out_blue,
  output logic                             modified
);

  logic                          is_pixel;
  logic                          wrap_hit;
  logic                          in_poly;
  logic                          in_window;
  logic                          change;
  logic                          load;
  logic [pmcs_pkg::CHAN_W-1:0]   red_next;
  logic [pmcs_pkg::CHAN_W-1:0]   green_next;
  logic [pmcs_pkg::CHAN_W-1:0]   blue_next;
  logic [pmcs_pkg::WIN_W-1:0]    wx;
  logic [pmcs_pkg::WIN_W-1:0]    wy;

  function automatic logic [pmcs_pkg::CHAN_W-1:0] darken(
    input logic [pmcs_pkg::CHAN_W-1:0] chan,
    input logic [pmcs_pkg::AMT_W-1:0]  amt
  );
    logic [pmcs_pkg::AMT_W-1:0] wide;
    wide = pmcs_pkg::AMT_W'(chan);
    return (wide > amt) ? pmcs_pkg::CHAN_W'(wide - amt) : '0;
  endfunction

  assign is_pixel = in_item.cmd == pmcs_pkg::CMD_PIXEL;
  assign wrap_hit = pmcs_pkg::crosses(in_item.px, in_item.py,
                                      in_item.first_x, in_item.first_y,
                                      in_item.prev_x, in_item.prev_y);
  assign in_poly  = in_item.parity ^ (in_item.has_prev && wrap_hit);

  assign wx = pmcs_pkg::WIN_W'(in_item.px);
  assign wy = pmcs_pkg::WIN_W'(in_item.py);
  assign in_window = (wy >= pmcs_pkg::WIN_W'(cfg.row_first)) &&
                     (wy < pmcs_pkg::WIN_W'(cfg.row_last)) &&
                     (wx >= pmcs_pkg::WIN_W'(pmcs_pkg::BORDER)) &&
                     (wx + pmcs_pkg::WIN_W'(pmcs_pkg::BORDER) <
                      pmcs_pkg::WIN_W'(cfg.image_width));
  assign change = in_window && !in_poly;

  assign red_next   = change ? darken(in_item.r, cfg.amt_red)   : in_item.r;
  assign green_next = change ? darken(in_item.g, cfg.amt_green) : in_item.g;
  assign blue_next  = change ? darken(in_item.b, cfg.amt_blue)  : in_item.b;

  // hold the chain only while a pixel waits on a full output register
  assign advance = !(in_valid && is_pixel && out_valid && !out_ready);
  assign load    = advance && in_valid && is_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_red   <= red_next;
      out_green <= green_next;
      out_blue  <= blue_next;
      modified  <= change;
    end
  end

`ifndef SYNTHESIS
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    !advance |-> out_valid && !out_ready)
    else $error("chain held without a waiting result");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    load && !change |=> !modified && out_red == $past(in_item.r) &&
      out_green == $past(in_item.g) && out_blue == $past(in_item.b))
    else $error("unchanged pixel altered");

  a_darken_bound: assert property (@(posedge clk) disable iff (rst)
    load && change |=> modified && out_red <= $past(in_item.r) &&
      out_green <= $past(in_item.g) && out_blue <= $past(in_item.b))
    else $error("darkened channel grew");
`endif

endmodule

`default_nettype wire

>>> sv/polygon_mask_color_subtract.sv
// Top level of the polygon mask color subtract block: APB registers, the
// vertex cell chain and the finishing stage. Depends on pmcs_pkg and all pmcs_ modules.
//
// Usage:
//   Input channel (in_valid/in_ready) carries items of two kinds. cmd = 0
//   writes vertex (pos_x, pos_y) into slot vertex_index and yields no result;
//   cmd = 1 is a pixel (pos_x, pos_y, in_red/green/blue) and yields exactly one
//   result item on the output channel (out_valid/out_ready).
//   Items travel a chain of 32 vertex cells, one cell per cycle while the chain
//   is not stalled, then the output register, and one item is accepted per
//   cycle when the output is drained. Items stay in order, so a vertex write
//   affects only pixels accepted after it.
//   The subtract amounts are rescaled from the power register through a registered
//   product and scaled value; configure over APB only while no item is in flight.
//   Stall: while a pixel at the chain end meets a full, untaken output
//   register, the whole chain holds and in_ready drops; otherwise the chain
//   keeps moving. Reset clears the configuration and valid flags and empties the
//   chain; vertex slots hold garbage until written.
`default_nettype none

module polygon_mask_color_subtract (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pmcs_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [pmcs_pkg::DATA_W-1:0]      pwdata,
  output logic      [pmcs_pkg::DATA_W-1:0]      prdata,
  output logic                                  pready,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             cmd,
  input  wire logic [pmcs_pkg::VINDEX_W-1:0]    vertex_index,
  input  wire logic [pmcs_pkg::COORD_BITS-1:0]  pos_x,
  input  wire logic [pmcs_pkg::COORD_BITS-1:0]  pos_y,
  input  wire logic [pmcs_pkg::CHAN_W-1:0]      in_red,
  input  wire logic [pmcs_pkg::CHAN_W-1:0]      in_green,
  input  wire logic [pmcs_pkg::CHAN_W-1:0]      in_blue,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic      [pmcs_pkg::CHAN_W-1:0]      out_red,
  output logic      [pmcs_pkg::CHAN_W-1:0]      out_green,
  output logic      [pmcs_pkg::CHAN_W-1:0]      out_blue,
  output logic                                  modified
);

  pmcs_pkg::cfg_t  cfg;
  logic            advance;
  logic            chain_valid [0:pmcs_pkg::MAX_VERTICES];
  pmcs_pkg::item_t chain_item  [0:pmcs_pkg::MAX_VERTICES];

  pmcs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready = advance;

  always_comb begin
    chain_valid[0]         = in_valid;
    chain_item[0].cmd      = pmcs_pkg::cmd_t'(cmd);
    chain_item[0].vidx     = vertex_index;
    chain_item[0].px       = pos_x;
    chain_item[0].py       = pos_y;
    chain_item[0].r        = in_red;
    chain_item[0].g        = in_green;
    chain_item[0].b        = in_blue;
    chain_item[0].has_prev = 1'b0;
    chain_item[0].prev_x   = '0;
    chain_item[0].prev_y   = '0;
    chain_item[0].first_x  = '0;
    chain_item[0].first_y  = '0;
    chain_item[0].parity   = 1'b0;
  end

  for (genvar i = 0; i < pmcs_pkg::MAX_VERTICES; i++) begin : g_cell
    pmcs_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .cell_index  (pmcs_pkg::VIDX_W'(i)),
      .point_count (cfg.point_count),
      .in_valid    (chain_valid[i]),
      .in_item     (chain_item[i]),
      .out_valid   (chain_valid[i+1]),
      .out_item    (chain_item[i+1])
    );
  end

  pmcs_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (chain_valid[pmcs_pkg::MAX_VERTICES]),
    .in_item   (chain_item[pmcs_pkg::MAX_VERTICES]),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .modified  (modified)
  );

endmodule

`default_nettype wire

>>> bench/tb_polygon_mask_color_subtract.sv
// Self-checking testbench for polygon_mask_color_subtract: directed table, then random
// polygons and pixels checked against an in-bench even-odd mask predictor.
// Depends on pmcs_pkg and the polygon_mask_color_subtract RTL.
`default_nettype none

module tb_polygon_mask_color_subtract;
  import pmcs_pkg::*;

  localparam int CHAIN_LAT    = 33;
  localparam int DRAIN        = CHAIN_LAT + 8;
  localparam int HOLD_CYCLES  = 160;
  localparam int LIMIT        = 400000;
  localparam int N_PHASES     = 10;
  localparam int PHASE_ITEMS  = 140;
  localparam int N_SCRIPT     = 23;

  typedef struct packed {
    cmd_t                  op;
    logic [VINDEX_W-1:0]   slot;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [CHAN_W-1:0]     r;
    logic [CHAN_W-1:0]     g;
    logic [CHAN_W-1:0]     b;
  } stim_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    logic              hit;
  } shade_t;

  typedef struct packed {
    logic [PCNT_W-1:0]  points;
    logic [POWER_W-1:0] power;
    logic [CHAN_W-1:0]  sub_r;
    logic [CHAN_W-1:0]  sub_g;
    logic [CHAN_W-1:0]  sub_b;
    logic [SPAN_W-1:0]  width;
    logic [SPAN_W-1:0]  row_first;
    logic [SPAN_W-1:0]  row_last;
  } setup_t;

  typedef struct packed {
    logic [1:0] sel;
    stim_t      stim;
    logic       fixed;
    shade_t     want;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  cmd = 1'b0;
  logic [VINDEX_W-1:0]   vertex_index = '0;
  logic [COORD_BITS-1:0] pos_x = '0;
  logic [COORD_BITS-1:0] pos_y = '0;
  logic [CHAN_W-1:0]     in_red = '0;
  logic [CHAN_W-1:0]     in_green = '0;
  logic [CHAN_W-1:0]     in_blue = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAN_W-1:0]     out_red;
  logic [CHAN_W-1:0]     out_green;
  logic [CHAN_W-1:0]     out_blue;
  logic                  modified;

  polygon_mask_color_subtract uut (.*);

  always #2 clk = ~clk;

  logic [COORD_BITS-1:0] poly_x [MAX_VERTICES];
  logic [COORD_BITS-1:0] poly_y [MAX_VERTICES];
  logic [PCNT_W-1:0]     cfg_points = '0;
  logic [POWER_W-1:0]    cfg_power = '0;
  logic [CHAN_W-1:0]     cfg_sub_r = '0;
  logic [CHAN_W-1:0]     cfg_sub_g = '0;
  logic [CHAN_W-1:0]     cfg_sub_b = '0;
  logic [SPAN_W-1:0]     cfg_width = '0;
  logic [SPAN_W-1:0]     cfg_row_first = '0;
  logic [SPAN_W-1:0]     cfg_row_last = '0;

  shade_t owed_shades[$];
  int     errors = 0;
  int     cycles = 0;
  int     n_pixels = 0;
  int     n_vertices = 0;
  int     n_setups = 0;
  int     n_checked = 0;
  int     hold_asked = 0;
  bit     calm = 1'b0;
  int     box_x = 2048;
  int     box_y = 2048;
  int     box_r = 500;

  function automatic logic [COORD_BITS-1:0] clip12(int v);
    return (v < 0) ? '0 : (v > 4095) ? 12'd4095 : COORD_BITS'(v);
  endfunction

  function automatic stim_t pix(int x, int y, int r, int g, int b);
    stim_t s;
    s.op = CMD_PIXEL;
    s.slot = VINDEX_W'($urandom_range(0, 31));
    s.x = COORD_BITS'(x);
    s.y = COORD_BITS'(y);
    s.r = CHAN_W'(r);
    s.g = CHAN_W'(g);
    s.b = CHAN_W'(b);
    return s;
  endfunction

  function automatic stim_t vtx(int slot, int x, int y);
    stim_t s;
    s = pix(x, y, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    s.op = CMD_VERTEX;
    s.slot = VINDEX_W'(slot);
    return s;
  endfunction

  function automatic shade_t shade(int r, int g, int b, int m);
    shade_t o;
    o.r = CHAN_W'(r);
    o.g = CHAN_W'(g);
    o.b = CHAN_W'(b);
    o.hit = m[0];
    return o;
  endfunction

  function automatic logic [CHAN_W-1:0] fade(logic [CHAN_W-1:0] c, logic [CHAN_W-1:0] amt);
    int cut;
    cut = int'(amt) * int'(cfg_power) / 100;
    return (int'(c) > cut) ? CHAN_W'(int'(c) - cut) : '0;
  endfunction

  function automatic logic in_polygon(int px, int py);
    int     n;
    int     i;
    int     prev;
    int     hits;
    longint xi, yi, xj, yj, d, lhs, rhs;
    n = (cfg_points > MAX_VERTICES) ? MAX_VERTICES : int'(cfg_points);
    hits = 0;
    prev = n - 1;
    for (i = 0; i < n; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[prev];
      yj = poly_y[prev];
      if ((yi > py) != (yj > py)) begin
        d = yj - yi;
        lhs = (px - xi) * d;
        rhs = (xj - xi) * (py - yi);
        if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) hits++;
      end
      prev = i;
    end
    return hits[0];
  endfunction

  function automatic shade_t shade_pixel(stim_t s);
    shade_t o;
    int     x, y;
    logic   win;
    x = s.x;
    y = s.y;
    win = (y >= int'(cfg_row_first)) && (y < int'(cfg_row_last)) &&
          (x >= BORDER) && (x + BORDER < int'(cfg_width));
    o.hit = win && !in_polygon(x, y);
    o.r = o.hit ? fade(s.r, cfg_sub_r) : s.r;
    o.g = o.hit ? fade(s.g, cfg_sub_g) : s.g;
    o.b = o.hit ? fade(s.b, cfg_sub_b) : s.b;
    return o;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 19);
    if (calm || k < 14) return 0;
    if (k < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic int pick_chan();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic setup_t roll_setup(int ph);
    setup_t u;
    if (ph == 0) return '{6'd63, 7'd127, 8'd255, 8'd255, 8'd255, 13'd8191, 13'd0, 13'd8191};
    if (ph == 1) return '{6'd0, 7'd0, 8'd0, 8'd0, 8'd0, 13'd4096, 13'd0, 13'd4096};
    case ($urandom_range(0, 7))
      0: u.points = '0;
      1: u.points = PCNT_W'($urandom_range(1, 2));
      2: u.points = PCNT_W'(32);
      3: u.points = PCNT_W'($urandom_range(33, 63));
      default: u.points = PCNT_W'($urandom_range(3, 31));
    endcase
    case ($urandom_range(0, 5))
      0: u.power = '0;
      1: u.power = POWER_W'(100);
      2: u.power = POWER_W'($urandom_range(101, 127));
      default: u.power = POWER_W'($urandom_range(1, 99));
    endcase
    u.sub_r = CHAN_W'(pick_chan());
    u.sub_g = CHAN_W'(pick_chan());
    u.sub_b = CHAN_W'(pick_chan());
    case ($urandom_range(0, 9))
      0: u.width = SPAN_W'($urandom_range(0, 10));
      1: u.width = SPAN_W'(11);
      2: u.width = SPAN_W'(8191);
      3: u.width = SPAN_W'(4096);
      default: u.width = SPAN_W'($urandom_range(12, 4096));
    endcase
    case ($urandom_range(0, 9))
      0: begin
        u.row_first = SPAN_W'($urandom_range(0, 8191));
        u.row_last = SPAN_W'($urandom_range(0, 8191));
      end
      1: begin
        u.row_first = '0;
        u.row_last = SPAN_W'(8191);
      end
      default: begin
        u.row_first = SPAN_W'($urandom_range(0, 1500));
        u.row_last = SPAN_W'($urandom_range(2500, 4096));
      end
    endcase
    return u;
  endfunction

  function automatic stim_t roll_pixel();
    int   v, x, y;
    x = $urandom_range(0, 4095);
    y = $urandom_range(0, 4095);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        x = box_x - box_r - 20 + int'($urandom_range(0, 2 * box_r + 40));
        y = box_y - box_r - 20 + int'($urandom_range(0, 2 * box_r + 40));
      end
      4: begin
        v = $urandom_range(0, MAX_VERTICES - 1);
        x = int'(poly_x[v]) + int'($urandom_range(0, 2)) - 1;
        y = int'(poly_y[v]) + int'($urandom_range(0, 2)) - 1;
      end
      5: begin
        case ($urandom_range(0, 3))
          0: x = BORDER - 1;
          1: x = BORDER;
          2: x = int'(cfg_width) - BORDER - 1;
          default: x = int'(cfg_width) - BORDER;
        endcase
        case ($urandom_range(0, 3))
          0: y = int'(cfg_row_first) - 1;
          1: y = int'(cfg_row_first);
          2: y = int'(cfg_row_last) - 1;
          default: y = int'(cfg_row_last);
        endcase
      end
      default: ;
    endcase
    return pix(clip12(x), clip12(y), pick_chan(), pick_chan(), pick_chan());
  endfunction

  task automatic offer(stim_t s, logic fixed, shade_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= s.op;
    vertex_index <= s.slot;
    pos_x <= s.x;
    pos_y <= s.y;
    in_red <= s.r;
    in_green <= s.g;
    in_blue <= s.b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (s.op == CMD_VERTEX) begin
      poly_x[s.slot] = s.x;
      poly_y[s.slot] = s.y;
      n_vertices++;
    end else begin
      owed_shades.push_back(fixed ? want : shade_pixel(s));
      n_pixels++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (owed_shades.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_POINT_COUNT: cfg_points = val[PCNT_W-1:0];
      REG_POWER:       cfg_power = val[POWER_W-1:0];
      REG_SUB_RED:     cfg_sub_r = val[CHAN_W-1:0];
      REG_SUB_GREEN:   cfg_sub_g = val[CHAN_W-1:0];
      REG_SUB_BLUE:    cfg_sub_b = val[CHAN_W-1:0];
      REG_IMAGE_WIDTH: cfg_width = val[SPAN_W-1:0];
      REG_ROW_FIRST:   cfg_row_first = val[SPAN_W-1:0];
      REG_ROW_LAST:    cfg_row_last = val[SPAN_W-1:0];
      default: ;
    endcase
  endtask

  // write the color terms first so their rescale settles before any item
  task automatic apply_setup(setup_t u);
    reg_write(REG_SUB_RED, DATA_W'(u.sub_r));
    reg_write(REG_SUB_GREEN, DATA_W'(u.sub_g));
    reg_write(REG_SUB_BLUE, DATA_W'(u.sub_b));
    reg_write(REG_POWER, DATA_W'(u.power));
    reg_write(REG_POINT_COUNT, DATA_W'(u.points));
    reg_write(REG_IMAGE_WIDTH, DATA_W'(u.width));
    reg_write(REG_ROW_FIRST, DATA_W'(u.row_first));
    reg_write(REG_ROW_LAST, DATA_W'(u.row_last));
    n_setups++;
  endtask

  task automatic check_result();
    shade_t want;
    n_checked++;
    if (owed_shades.size() == 0) begin
      $error("result with no pixel pending");
      errors++;
    end else begin
      want = owed_shades.pop_front();
      if (out_red !== want.r) begin
        $error("out_red: expected %0d, actual %0d", want.r, out_red);
        errors++;
      end
      if (out_green !== want.g) begin
        $error("out_green: expected %0d, actual %0d", want.g, out_green);
        errors++;
      end
      if (out_blue !== want.b) begin
        $error("out_blue: expected %0d, actual %0d", want.b, out_blue);
        errors++;
      end
      if (modified !== want.hit) begin
        $error("modified: expected %0d, actual %0d", want.hit, modified);
        errors++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_polygon_mask_color_subtract failed");
      $finish;
    end
  end

  initial begin : result_side
    int stall;
    int hold_done;
    stall = 0;
    hold_done = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end
    end
  end

  initial begin : stimulus
    step_t  script [N_SCRIPT];
    setup_t presets [4];
    setup_t u;
    stim_t  s;
    int     k, ph, nv, cur;
    bit     snap;

    presets[0] = '0;
    presets[1] = '{6'd4, 7'd100, 8'd255, 8'd255, 8'd255, 13'd4096, 13'd0, 13'd4096};
    presets[2] = '{6'd2, 7'd127, 8'd255, 8'd128, 8'd1, 13'd11, 13'd100, 13'd101};
    presets[3] = '{6'd3, 7'd50, 8'd10, 8'd20, 8'd30, 13'd10, 13'd200, 13'd100};

    script = '{
      '{2'd0, pix(0, 0, 0, 0, 0), 1'b1, shade(0, 0, 0, 0)},
      '{2'd0, pix(4095, 4095, 255, 255, 255), 1'b1, shade(255, 255, 255, 0)},
      '{2'd0, pix(2048, 1024, 170, 85, 15), 1'b1, shade(170, 85, 15, 0)},
      '{2'd0, vtx(0, 1000, 1000), 1'b0, shade(0, 0, 0, 0)},
      '{2'd0, vtx(1, 3000, 1000), 1'b0, shade(0, 0, 0, 0)},
      '{2'd0, vtx(2, 3000, 3000), 1'b0, shade(0, 0, 0, 0)},
      '{2'd0, vtx(3, 1000, 3000), 1'b0, shade(0, 0, 0, 0)},
      '{2'd0, vtx(31, 4095, 4095), 1'b0, shade(0, 0, 0, 0)},
      '{2'd1, pix(2000, 2000, 12, 34, 56), 1'b1, shade(12, 34, 56, 0)},
      '{2'd1, pix(5, 0, 200, 100, 50), 1'b1, shade(0, 0, 0, 1)},
      '{2'd1, pix(4, 0, 200, 100, 50), 1'b1, shade(200, 100, 50, 0)},
      '{2'd1, pix(4090, 4095, 1, 2, 3), 1'b1, shade(0, 0, 0, 1)},
      '{2'd1, pix(4091, 10, 1, 2, 3), 1'b1, shade(1, 2, 3, 0)},
      '{2'd1, pix(1000, 1000, 90, 90, 90), 1'b0, shade(0, 0, 0, 0)},
      '{2'd1, pix(3000, 2000, 90, 90, 90), 1'b0, shade(0, 0, 0, 0)},
      '{2'd1, pix(2000, 1000, 90, 90, 90), 1'b0, shade(0, 0, 0, 0)},
      '{2'd2, pix(5, 100, 255, 255, 255), 1'b1, shade(0, 93, 254, 1)},
      '{2'd2, pix(6, 100, 255, 255, 255), 1'b1, shade(255, 255, 255, 0)},
      '{2'd2, pix(5, 101, 7, 8, 9), 1'b1, shade(7, 8, 9, 0)},
      '{2'd2, pix(5, 99, 7, 8, 9), 1'b1, shade(7, 8, 9, 0)},
      '{2'd3, vtx(2, 2000, 3000), 1'b0, shade(0, 0, 0, 0)},
      '{2'd3, pix(5, 150, 128, 64, 32), 1'b1, shade(128, 64, 32, 0)},
      '{2'd3, pix(2000, 2000, 255, 0, 255), 1'b0, shade(0, 0, 0, 0)}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur = 0;
    for (k = 0; k < N_SCRIPT; k++) begin
      if (int'(script[k].sel) != cur) begin
        wait_idle();
        cur = script[k].sel;
        apply_setup(presets[cur]);
      end
      offer(script[k].stim, script[k].fixed, script[k].want);
    end

    // fill every slot so any point count reads written vertices
    for (k = 0; k < MAX_VERTICES; k++)
      offer(vtx(k, $urandom_range(0, 4095), $urandom_range(0, 4095)), 1'b0, '0);

    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_idle();
      calm = (ph % 4 == 3);
      u = roll_setup(ph);
      apply_setup(u);
      box_x = $urandom_range(400, 3700);
      box_y = $urandom_range(400, 3700);
      box_r = ($urandom_range(0, 3) == 0) ? $urandom_range(1000, 2000) : $urandom_range(20, 400);
      snap = ($urandom_range(0, 2) == 0);
      nv = (u.points > MAX_VERTICES) ? MAX_VERTICES : int'(u.points);
      for (k = 0; k < nv; k++) begin
        if (snap)
          s = vtx(k, clip12(box_x + (int'($urandom_range(0, 4)) - 2) * (box_r / 2)),
                  clip12(box_y + (int'($urandom_range(0, 4)) - 2) * (box_r / 2)));
        else
          s = vtx(k, clip12(box_x - box_r + int'($urandom_range(0, 2 * box_r))),
                  clip12(box_y - box_r + int'($urandom_range(0, 2 * box_r))));
        offer(s, 1'b0, '0);
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 30) hold_asked++;
        if ($urandom_range(0, 19) == 0)
          s = vtx($urandom_range(0, 31), $urandom_range(0, 4095), $urandom_range(0, 4095));
        else
          s = roll_pixel();
        offer(s, 1'b0, '0);
      end
    end

    wait_idle();
    $display("covered %0d pixels and %0d vertex writes under %0d register setups",
             n_pixels, n_vertices, n_setups);
    $display("checked %0d results, %0d mismatches", n_checked, errors);
    if (errors == 0)
      $display("tb_polygon_mask_color_subtract passed");
    else
      $display("tb_polygon_mask_color_subtract failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
sv/pmcs_pkg.sv
sv/pmcs_cfg.sv
sv/pmcs_cell.sv
sv/pmcs_finish.sv
sv/polygon_mask_color_subtract.sv
bench/tb_polygon_mask_color_subtract.sv
